### rtl/sfpp_pkg.sv
// ----------------------------------------------------------------------------
// sfpp_pkg : shared types and constants for the far point pair core
// Coordinate and distance widths, and the point count state encoding.
// ----------------------------------------------------------------------------
package sfpp_pkg;

    localparam int COORD_WIDTH = 16;
    // |dx|^2 + |dy|^2 needs one bit above the square width
    localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
    localparam int DIST_WIDTH  = SQ_WIDTH + 1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [DIST_WIDTH-1:0]         dist_t;

    // points taken in the current set, saturating at two
    typedef enum logic [2:0] {
        SEEN_NONE = 3'b001,
        SEEN_ONE  = 3'b010,
        SEEN_TWO  = 3'b100
    } seen_t;

endpackage

### rtl/sfpp_in_if.sv
// ----------------------------------------------------------------------------
// sfpp_in_if : point stream channel
// Valid/ready channel carrying one 2-D point and an end-of-set mark per beat.
// ----------------------------------------------------------------------------
interface sfpp_in_if
    import sfpp_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    logic   last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

### rtl/sfpp_out_if.sv
// ----------------------------------------------------------------------------
// sfpp_out_if : point pair result channel
// Valid/ready channel carrying the chosen end points and the short-set flag.
// ----------------------------------------------------------------------------
interface sfpp_out_if
    import sfpp_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t end_a_x;
    coord_t end_a_y;
    coord_t end_b_x;
    coord_t end_b_y;
    logic   too_few_points;

    modport source (output valid, end_a_x, end_a_y, end_b_x, end_b_y,
                    too_few_points, input ready);
    modport sink   (input valid, end_a_x, end_a_y, end_b_x, end_b_y,
                    too_few_points, output ready);
endinterface

### rtl/streaming_far_point_pair_core.sv
// ----------------------------------------------------------------------------
// streaming_far_point_pair_core : streaming far-apart point pair tracker
// Keeps a candidate pair A/B over a point set and emits it on the last point.
// ----------------------------------------------------------------------------
// Path: the last point passes the input register, then the result register.
// Throughput: one point per cycle while no last point waits; the pair update
//   (three squared distances, compare and select) is combinational.
// A last point waits in the input register only while a result is held unread.
// Reset: asynchronous, active low; clears the beat valids and the point count.
// ----------------------------------------------------------------------------
module streaming_far_point_pair_core
    import sfpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sfpp_in_if.sink    pt_in,
    sfpp_out_if.source pair_out
);

    // input register
    logic   s1_valid_reg;
    coord_t s1_x_reg;
    coord_t s1_y_reg;
    logic   s1_last_reg;

    // candidate pair and point count
    coord_t a_x_reg, a_y_reg, b_x_reg, b_y_reg;
    coord_t a_x_next, a_y_next, b_x_next, b_y_next;
    seen_t  seen_reg, seen_next;

    // pair after this point, before any end-of-set clear
    coord_t a_x_upd, a_y_upd, b_x_upd, b_y_upd;

    // result register
    logic   out_valid_reg;
    coord_t out_a_x_reg, out_a_y_reg, out_b_x_reg, out_b_y_reg;
    logic   out_few_reg;

    logic   out_free;
    logic   s1_go;
    dist_t  d_ab, d_ac, d_bc;
    logic   grow;
    logic   repl_a;

    // ------------------------------------------------------------------
    // Handshake: non-last points never touch the result register, so they
    // move on regardless of the output side; a last point needs a free slot.
    // ------------------------------------------------------------------
    assign out_free    = !out_valid_reg || pair_out.ready;
    assign s1_go       = s1_valid_reg && (!s1_last_reg || out_free);
    assign pt_in.ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pt_in.ready)
        begin
            s1_valid_reg <= pt_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pt_in.valid && pt_in.ready)
        begin
            s1_x_reg    <= pt_in.point_x;
            s1_y_reg    <= pt_in.point_y;
            s1_last_reg <= pt_in.last_point;
        end
    end

    // ------------------------------------------------------------------
    // Distances from the stored pair and the incoming point C
    // ------------------------------------------------------------------
    sfpp_sq_dist u_dist_ab (
        .x1     (a_x_reg),
        .y1     (a_y_reg),
        .x2     (b_x_reg),
        .y2     (b_y_reg),
        .sq_sum (d_ab)
    );

    sfpp_sq_dist u_dist_ac (
        .x1     (a_x_reg),
        .y1     (a_y_reg),
        .x2     (s1_x_reg),
        .y2     (s1_y_reg),
        .sq_sum (d_ac)
    );

    sfpp_sq_dist u_dist_bc (
        .x1     (b_x_reg),
        .y1     (b_y_reg),
        .x2     (s1_x_reg),
        .y2     (s1_y_reg),
        .sq_sum (d_bc)
    );

    // C lengthens the pair if it is strictly further from A or B than AB;
    // it then replaces A unless AC is the longest (ties favour replacing B)
    assign grow   = (d_ac > d_ab) || (d_bc > d_ab);
    assign repl_a = (d_ab > d_ac) || (d_bc > d_ac);

    always_comb
    begin
        a_x_upd   = a_x_reg;
        a_y_upd   = a_y_reg;
        b_x_upd   = b_x_reg;
        b_y_upd   = b_y_reg;
        seen_next = seen_reg;

        unique case (seen_reg)
            SEEN_NONE:
            begin
                a_x_upd   = s1_x_reg;
                a_y_upd   = s1_y_reg;
                seen_next = SEEN_ONE;
            end
            SEEN_ONE:
            begin
                b_x_upd   = s1_x_reg;
                b_y_upd   = s1_y_reg;
                seen_next = SEEN_TWO;
            end
            SEEN_TWO:
            begin
                if (grow)
                begin
                    if (repl_a)
                    begin
                        a_x_upd = s1_x_reg;
                        a_y_upd = s1_y_reg;
                    end
                    else
                    begin
                        b_x_upd = s1_x_reg;
                        b_y_upd = s1_y_reg;
                    end
                end
            end
            default:
            begin
                seen_next = SEEN_NONE;
            end
        endcase

        // end of set: the next beat starts afresh
        if (s1_last_reg)
        begin
            seen_next = SEEN_NONE;
        end

        a_x_next = a_x_upd;
        a_y_next = a_y_upd;
        b_x_next = b_x_upd;
        b_y_next = b_y_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= SEEN_NONE;
        end
        else if (s1_go)
        begin
            seen_reg <= seen_next;
        end
    end

    // pair contents are don't-care while the count is at none
    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            a_x_reg <= a_x_next;
            a_y_reg <= a_y_next;
            b_x_reg <= b_x_next;
            b_y_reg <= b_y_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pair_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // a one-point set reports zeros and the flag
    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            if (seen_reg == SEEN_NONE)
            begin
                out_a_x_reg <= '0;
                out_a_y_reg <= '0;
                out_b_x_reg <= '0;
                out_b_y_reg <= '0;
                out_few_reg <= 1'b1;
            end
            else
            begin
                out_a_x_reg <= a_x_upd;
                out_a_y_reg <= a_y_upd;
                out_b_x_reg <= b_x_upd;
                out_b_y_reg <= b_y_upd;
                out_few_reg <= 1'b0;
            end
        end
    end

    assign pair_out.valid          = out_valid_reg;
    assign pair_out.end_a_x        = out_a_x_reg;
    assign pair_out.end_a_y        = out_a_y_reg;
    assign pair_out.end_b_x        = out_b_x_reg;
    assign pair_out.end_b_y        = out_b_y_reg;
    assign pair_out.too_few_points = out_few_reg;

endmodule

### rtl/sfpp_sq_dist.sv
// ----------------------------------------------------------------------------
// sfpp_sq_dist : exact squared Euclidean distance
// Two absolute differences, two unsigned squares and one add; combinational.
// ----------------------------------------------------------------------------
module sfpp_sq_dist
    import sfpp_pkg::*;
(
    input  coord_t x1,
    input  coord_t y1,
    input  coord_t x2,
    input  coord_t y2,
    output dist_t  sq_sum
);

    logic signed [COORD_WIDTH:0] dx;
    logic signed [COORD_WIDTH:0] dy;
    logic [COORD_WIDTH:0]        dx_neg;
    logic [COORD_WIDTH:0]        dy_neg;
    logic [COORD_WIDTH-1:0]      adx;
    logic [COORD_WIDTH-1:0]      ady;
    logic [SQ_WIDTH-1:0]         sqx;
    logic [SQ_WIDTH-1:0]         sqy;

    assign dx = {x1[COORD_WIDTH-1], x1} - {x2[COORD_WIDTH-1], x2};
    assign dy = {y1[COORD_WIDTH-1], y1} - {y2[COORD_WIDTH-1], y2};

    assign dx_neg = -dx;
    assign dy_neg = -dy;

    // magnitude never exceeds 2^W - 1, so W bits hold it
    assign adx = dx[COORD_WIDTH] ? dx_neg[COORD_WIDTH-1:0] : dx[COORD_WIDTH-1:0];
    assign ady = dy[COORD_WIDTH] ? dy_neg[COORD_WIDTH-1:0] : dy[COORD_WIDTH-1:0];

    assign sqx = adx * adx;
    assign sqy = ady * ady;

    assign sq_sum = {1'b0, sqx} + {1'b0, sqy};

endmodule

### dv/sfpp_pair_checker.sv
// ----------------------------------------------------------------------------
// sfpp_pair_checker : scoreboard for the far point pair core
// Watches both channels, keeps its own copy of the candidate pair, queues the
// pair expected for each closed set and compares every result beat with it.
// ----------------------------------------------------------------------------
module sfpp_pair_checker
    import sfpp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sfpp_in_if   pt_in,
    sfpp_out_if  pair_out,
    output int   mismatches,
    output int   pairs_waiting,
    output int   pairs_checked
);

    typedef struct packed {
        coord_t a_x;
        coord_t a_y;
        coord_t b_x;
        coord_t b_y;
        logic   too_few;
    } pair_beat_t;

    coord_t     cand_a_x;
    coord_t     cand_a_y;
    coord_t     cand_b_x;
    coord_t     cand_b_y;
    seen_t      set_fill;
    pair_beat_t expected_pairs[$];
    pair_beat_t got_pair;

    // exact squared distance; fits easily in 64 bits at 16-bit coordinates
    function automatic longint sq_span(input coord_t x1, input coord_t y1,
                                       input coord_t x2, input coord_t y2);
        longint dx;
        longint dy;
        dx = longint'(x1) - longint'(x2);
        dy = longint'(y1) - longint'(y2);
        return dx * dx + dy * dy;
    endfunction

    task automatic take_point(input coord_t cx, input coord_t cy, input logic last);
        longint     ab;
        longint     ac;
        longint     bc;
        pair_beat_t res;
        case (set_fill)
            SEEN_NONE:
            begin
                cand_a_x = cx;
                cand_a_y = cy;
                set_fill = SEEN_ONE;
            end
            SEEN_ONE:
            begin
                cand_b_x = cx;
                cand_b_y = cy;
                set_fill = SEEN_TWO;
            end
            default:
            begin
                ab = sq_span(cand_a_x, cand_a_y, cand_b_x, cand_b_y);
                ac = sq_span(cand_a_x, cand_a_y, cx, cy);
                bc = sq_span(cand_b_x, cand_b_y, cx, cy);
                // ties never widen; an inner tie drops B
                if (ac > ab || bc > ab)
                begin
                    if (ab > ac || bc > ac)
                    begin
                        cand_a_x = cx;
                        cand_a_y = cy;
                    end
                    else
                    begin
                        cand_b_x = cx;
                        cand_b_y = cy;
                    end
                end
            end
        endcase
        if (last)
        begin
            res = '0;
            if (set_fill != SEEN_TWO)
                res.too_few = 1'b1;
            else
                res = '{cand_a_x, cand_a_y, cand_b_x, cand_b_y, 1'b0};
            expected_pairs.push_back(res);
            cand_a_x = '0;
            cand_a_y = '0;
            cand_b_x = '0;
            cand_b_y = '0;
            set_fill = SEEN_NONE;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    task automatic compare_pair(input pair_beat_t got);
        pair_beat_t want;
        if (expected_pairs.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected pair beat, expected none actual a=(%0d,%0d) b=(%0d,%0d) short=%0b",
                     $time, got.a_x, got.a_y, got.b_x, got.b_y, got.too_few);
            return;
        end
        want = expected_pairs.pop_front();
        pairs_checked++;
        check_field("end_a_x", want.a_x, got.a_x);
        check_field("end_a_y", want.a_y, got.a_y);
        check_field("end_b_x", want.b_x, got.b_x);
        check_field("end_b_y", want.b_y, got.b_y);
        check_field("too_few_points", want.too_few, got.too_few);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_a_x      = '0;
            cand_a_y      = '0;
            cand_b_x      = '0;
            cand_b_y      = '0;
            set_fill      = SEEN_NONE;
            mismatches    = 0;
            pairs_checked = 0;
            expected_pairs.delete();
            pairs_waiting <= 0;
        end
        else
        begin
            // a result beat always belongs to an earlier point beat
            if (pair_out.valid && pair_out.ready)
            begin
                got_pair = '{pair_out.end_a_x, pair_out.end_a_y, pair_out.end_b_x,
                             pair_out.end_b_y, pair_out.too_few_points};
                compare_pair(got_pair);
            end
            if (pt_in.valid && pt_in.ready)
                take_point(pt_in.point_x, pt_in.point_y, pt_in.last_point);
            pairs_waiting <= expected_pairs.size();
        end
    end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench : far point pair core test
// Directed sets for short sets, ties and extreme coordinates, then random
// sets of mixed length and spread, with random idling on both channels.
// Checking is done by sfpp_pair_checker alongside the core.
// ----------------------------------------------------------------------------
module testbench;
    import sfpp_pkg::*;

    localparam int RANDOM_POINTS   = 2000;
    localparam int DIRECTED_POINTS = 24;
    localparam int PAUSE_EVERY     = 500;
    // guard on the run length, ample for the worst case of the points sent
    localparam int CYCLE_LIMIT     = 1_000_000;

    // how the coordinates of a random set are spread
    typedef enum int {
        SPREAD_FULL,
        SPREAD_NEAR,
        SPREAD_EDGE,
        SPREAD_MIXED
    } spread_t;

    logic    clk;
    logic    rst_n;
    int      mismatches;
    int      pairs_waiting;
    int      pairs_checked;
    int      points_sent;
    int      sets_sent;
    int      short_sets;
    int      set_len;
    int      points_in_set;
    int      next_pause;
    int      stall_cycles;
    int      cycle_count;
    bit      calm;            // no idling on either side while set
    spread_t spread;

    // directed points: x, y, last
    int directed_pts[DIRECTED_POINTS][3] = '{
        // single-point sets: flagged short, coordinates zero
        '{-32768, 32767, 1},
        '{32767, -32768, 1},
        // two points at opposite corners
        '{-32768, -32768, 0}, '{32767, 32767, 1},
        // all points equal: nothing is ever replaced
        '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 1},
        // BC is the longest: A goes
        '{0, 0, 0}, '{1, 0, 0}, '{-1, 0, 1},
        // AC is the longest: B goes
        '{0, 0, 0}, '{1, 0, 0}, '{2, 0, 1},
        // AC equals BC, both above AB: the tie drops B
        '{0, 0, 0}, '{2, 0, 0}, '{1, 5, 1},
        // AC equals AB, BC longer: A goes
        '{0, 0, 0}, '{3, 0, 0}, '{0, 3, 1},
        // extreme spans in the update path
        '{-32768, -32768, 0}, '{0, 0, 0}, '{32767, 32767, 0}, '{-1, -1, 0},
        '{32767, -32768, 1}
    };

    coord_t edge_values[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

    sfpp_in_if  pt_in();
    sfpp_out_if pair_out();

    streaming_far_point_pair_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .pt_in    (pt_in),
        .pair_out (pair_out)
    );

    sfpp_pair_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .pt_in         (pt_in),
        .pair_out      (pair_out),
        .mismatches    (mismatches),
        .pairs_waiting (pairs_waiting),
        .pairs_checked (pairs_checked)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int draw_idle();
        return calm ? 0 : int'($urandom_range(0, 19));
    endfunction

    function automatic coord_t pick_coord(input spread_t how);
        if (how == SPREAD_MIXED)
            how = spread_t'($urandom_range(0, 2));
        case (how)
            SPREAD_NEAR: return coord_t'(int'($urandom_range(0, 16)) - 8);
            SPREAD_EDGE: return edge_values[$urandom_range(0, 6)];
            default:     return coord_t'($urandom);
        endcase
    endfunction

    // One point beat. Valid is only dropped when a gap is drawn, so a
    // back-to-back beat keeps valid high with a single assignment per step.
    task automatic send_point(input coord_t x, input coord_t y, input logic last);
        int gap;
        gap = draw_idle();
        if (gap > 0)
        begin
            pt_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pt_in.valid      <= 1'b1;
        pt_in.point_x    <= x;
        pt_in.point_y    <= y;
        pt_in.last_point <= last;
        do @(posedge clk); while (!pt_in.ready);
        points_sent++;
        points_in_set++;
        if (last)
        begin
            sets_sent++;
            if (points_in_set < 2)
                short_sets++;
            points_in_set = 0;
        end
    endtask

    // stop sending until every queued pair has been read back
    task automatic hold_until_drained();
        pt_in.valid <= 1'b0;
        do @(posedge clk); while (pairs_waiting != 0);
    endtask

    // Result side: a drawn stall holds ready low until a beat has been
    // offered and for the stall after that; zero keeps ready high.
    initial
    begin
        pair_out.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall_cycles = draw_idle();
            if (stall_cycles == 0)
                pair_out.ready <= 1'b1;
            else
            begin
                pair_out.ready <= 1'b0;
                do @(posedge clk); while (!pair_out.valid);
                repeat (stall_cycles - 1) @(posedge clk);
                pair_out.ready <= 1'b1;
            end
            do @(posedge clk); while (!pair_out.valid);
        end
    end

    initial
    begin
        calm             = 1'b0;
        cycle_count      = 0;
        rst_n            <= 1'b0;
        pt_in.valid      <= 1'b0;
        pt_in.point_x    <= '0;
        pt_in.point_y    <= '0;
        pt_in.last_point <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed sets
        for (int i = 0; i < DIRECTED_POINTS; i++)
            send_point(coord_t'(directed_pts[i][0]), coord_t'(directed_pts[i][1]),
                       directed_pts[i][2] != 0);
        hold_until_drained();

        // Random sets: mostly short, a few long enough to walk the pair a
        // good way; single-point sets keep the short-set flag exercised.
        next_pause = DIRECTED_POINTS + PAUSE_EVERY;
        while (points_sent - DIRECTED_POINTS < RANDOM_POINTS)
        begin
            if ($urandom_range(0, 29) == 0)
                calm = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 9))
                0:       set_len = 1;
                7, 8:    set_len = $urandom_range(7, 20);
                9:       set_len = $urandom_range(21, 60);
                default: set_len = $urandom_range(2, 6);
            endcase
            spread = spread_t'($urandom_range(0, 3));
            for (int i = 0; i < set_len; i++)
                send_point(pick_coord(spread), pick_coord(spread), i == set_len - 1);
            if (points_sent >= next_pause)
            begin
                hold_until_drained();
                next_pause += PAUSE_EVERY;
            end
        end

        // drain, then leave room for any stray beat
        hold_until_drained();
        repeat (8) @(posedge clk);

        $display("Sent %0d points in %0d sets, %0d of them short; %0d pairs compared.",
                 points_sent, sets_sent, short_sets, pairs_checked);
        $display("Covered ties, corner coordinates, long sets and idling on both sides.");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
